### rtl/b64c_pkg.sv
package b64c_pkg;

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash = 8'h2F;  // '/'
  localparam logic [5:0] SextetMask = 6'h3F;

  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  // One group's worth of work handed from the front to the back.
  typedef struct packed {
    logic        enc;   // 1: emit base64 characters, 0: emit decoded bytes
    logic [23:0] bits;  // group bits, first item in the top bits
    logic [2:0]  cnt;   // results to emit, 1..4
    logic [1:0]  pads;  // encode only: trailing '=' characters
  } b64c_job_t;

  // Classified input character.
  typedef struct packed {
    logic       ok;   // in the alphabet or '='
    logic       pad;  // '='
    logic [5:0] val;  // sextet value, zero for '='
  } b64c_sym_t;

  // Front state visible to the top level.
  typedef struct packed {
    logic       mode;
    logic [1:0] grp_cnt;
    logic       halted;
  } b64c_stat_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  function automatic b64c_sym_t dec_char(input logic [7:0] c);
    b64c_sym_t s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.ok  = 1'b1;
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == CharPlus) begin
      s.ok  = 1'b1;
      s.val = 6'd62;
    end else if (c == CharSlash) begin
      s.ok  = 1'b1;
      s.val = 6'd63;
    end else if (c == CharPad) begin
      s.ok  = 1'b1;
      s.pad = 1'b1;
    end
    return s;
  endfunction

endpackage

### rtl/b64c_front.sv
module b64c_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_mode,
  input  logic                 in_fire,
  input  logic [7:0]           in_data,
  input  logic                 in_eos,
  output logic                 job_push,
  output b64c_pkg::b64c_job_t  job,
  output b64c_pkg::b64c_stat_t stat
);

  logic        mode_r, mode_nxt;
  logic [23:0] buf_r, buf_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  pad_r, pad_nxt;
  logic        halt_r, halt_nxt;

  b64c_pkg::b64c_sym_t sym;
  logic [2:0]  pads_tot;
  logic [2:0]  pad_new;
  logic [23:0] flush_bits;
  logic [1:0]  missing;

  assign sym = b64c_pkg::dec_char(in_data);

  always_comb begin
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    pad_nxt  = pad_r;
    halt_nxt = halt_r;
    job_push = 1'b0;
    job      = '0;
    pad_new  = pad_r + {2'b00, sym.pad};
    pads_tot = '0;
    missing  = 2'd0;
    flush_bits = '0;

    // truncated decode group, left aligned and '='-filled
    case (cnt_r)
      2'd1: begin
        flush_bits = {buf_r[5:0], 18'b0};
        missing    = 2'd3;
      end
      2'd2: begin
        flush_bits = {buf_r[11:0], 12'b0};
        missing    = 2'd2;
      end
      2'd3: begin
        flush_bits = {buf_r[17:0], 6'b0};
        missing    = 2'd1;
      end
      default: begin
        flush_bits = '0;
        missing    = 2'd0;
      end
    endcase
    pads_tot = pad_r + {1'b0, missing};

    if (cfg_we) begin
      mode_nxt = cfg_mode;
      buf_nxt  = '0;
      cnt_nxt  = '0;
      pad_nxt  = '0;
      halt_nxt = 1'b0;
    end else if (in_fire) begin
      if (in_eos) begin
        if (mode_r == b64c_pkg::ModeEnc) begin
          job.enc = 1'b1;
          job.cnt = 3'd4;
          if (cnt_r == 2'd1) begin
            job_push  = 1'b1;
            job.bits  = {buf_r[7:0], 16'b0};
            job.pads  = 2'd2;
          end else if (cnt_r == 2'd2) begin
            job_push  = 1'b1;
            job.bits  = {buf_r[15:0], 8'b0};
            job.pads  = 2'd1;
          end
        end else if (!halt_r && cnt_r != 2'd0 && pads_tot < 3'd3) begin
          job_push = 1'b1;
          job.enc  = 1'b0;
          job.bits = flush_bits;
          job.cnt  = 3'd3 - pads_tot;
        end
        buf_nxt  = '0;
        cnt_nxt  = '0;
        pad_nxt  = '0;
        halt_nxt = 1'b0;
      end else if (mode_r == b64c_pkg::ModeEnc) begin
        buf_nxt = {buf_r[15:0], in_data};
        if (cnt_r == 2'd2) begin
          job_push = 1'b1;
          job.enc  = 1'b1;
          job.bits = {buf_r[15:0], in_data};
          job.cnt  = 3'd4;
          job.pads = 2'd0;
          buf_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end else if (!halt_r && sym.ok) begin
        buf_nxt = {buf_r[17:0], sym.val};
        if (cnt_r == 2'd3) begin
          if (pad_new >= 3'd4) begin
            halt_nxt = 1'b1;
          end else if (pad_new < 3'd3) begin
            job_push = 1'b1;
            job.enc  = 1'b0;
            job.bits = {buf_r[17:0], sym.val};
            job.cnt  = 3'd3 - pad_new;
          end
          buf_nxt = '0;
          cnt_nxt = '0;
          pad_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
          pad_nxt = pad_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64c_pkg::ModeEnc;
      buf_r  <= '0;
      cnt_r  <= '0;
      pad_r  <= '0;
      halt_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      pad_r  <= pad_nxt;
      halt_r <= halt_nxt;
    end
  end

  assign stat.mode    = mode_r;
  assign stat.grp_cnt = cnt_r;
  assign stat.halted  = halt_r;

endmodule

### rtl/b64c_queue.sv
module b64c_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b64c_pkg::b64c_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                vld,
  output b64c_pkg::b64c_job_t pop_job
);

  b64c_pkg::b64c_job_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign vld     = (cnt_r != 2'd0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/b64c_back.sv
module b64c_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_vld,
  input  b64c_pkg::b64c_job_t job,
  output logic                job_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  b64c_pkg::b64c_job_t cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;

  logic       last;
  logic [4:0] sh;
  logic [5:0] sextet;
  logic [7:0] byte_val;

  assign last = ({1'b0, idx_r} == cur_r.cnt - 3'd1);

  always_comb begin
    case (idx_r)
      2'd0:    sh = 5'd18;
      2'd1:    sh = 5'd12;
      2'd2:    sh = 5'd6;
      default: sh = 5'd0;
    endcase
    sextet = 6'((cur_r.bits >> sh) & {18'b0, b64c_pkg::SextetMask});
    if (cur_r.enc) begin
      if ({1'b0, idx_r} >= 3'd4 - {1'b0, cur_r.pads}) begin
        byte_val = b64c_pkg::CharPad;
      end else begin
        byte_val = b64c_pkg::enc_char(sextet);
      end
    end else begin
      case (idx_r)
        2'd0:    byte_val = cur_r.bits[23:16];
        2'd1:    byte_val = cur_r.bits[15:8];
        default: byte_val = cur_r.bits[7:0];
      endcase
    end
  end

  assign out_tvalid = cur_vld_r;
  assign out_tdata  = byte_val;
  assign out_tlast  = last;
  assign job_pop    = job_vld && (!cur_vld_r || (out_tready && last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (job_pop) begin
      cur_r     <= job;
      cur_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (cur_vld_r && out_tready) begin
      if (last) begin
        cur_vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

### rtl/base64_codec_stream_top.sv
// Streaming base64 codec (standard alphabet, '=' padding).
// cfg_*: one write selects the direction (0 encode, 1 decode) and clears the
//   group, pad count and halt flag. Write it only while the block is idle.
// in_*: one transfer per byte. in_tlast set means end of stream: the partial
//   group is flushed (encode pads with '=', decode fills with '=') and all
//   group state clears; in_tdata is ignored on such a transfer.
// out_*: one character or byte per transfer; out_tlast marks the final
//   result caused by one input transfer (the end of a group).
// The transfer that completes a group queues its job at that same edge and
//   the back then loads it into its register, so the first result is valid
//   once the job has passed the job queue and then the back register.
// Throughput: the back emits one result per cycle while out_tready is high,
//   so a group yields 4 results when encoding (3 input bytes) and 3 or
//   fewer when decoding (4 input characters); input is taken each cycle
//   while the two-entry job queue has room.
// Out-of-alphabet characters and characters after an all-'=' group take no
//   output cycles. A stalled out_tready holds the current result and fills
//   the queue, after which in_tready drops. Reset selects encode mode and
//   empties the queue and the output stage.
module base64_codec_stream_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,    // mode
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data
  input  logic       in_tlast,    // end of stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast    // group_last
);

  b64c_pkg::b64c_job_t  push_job;
  b64c_pkg::b64c_job_t  pop_job;
  b64c_pkg::b64c_stat_t stat;
  logic push, q_full, q_vld, pop;
  logic in_fire, cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Front: classifies bytes and builds group jobs.
  b64c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_mode (cfg_data),
    .in_fire  (in_fire),
    .in_data  (in_tdata),
    .in_eos   (in_tlast),
    .job_push (push),
    .job      (push_job),
    .stat     (stat)
  );

  // Two-entry job queue decouples input from output stalls.
  b64c_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .vld      (q_vld),
    .pop_job  (pop_job)
  );

  // Back: serializes each job, one result per transfer.
  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_vld    (q_vld),
    .job        (pop_job),
    .job_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // End of stream always leaves an empty group and clears the halt.
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> stat.grp_cnt == 2'd0 && !stat.halted)
    else $error("group state not cleared after end of stream");

  // Only decoding can halt.
  a_halt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |-> stat.mode == b64c_pkg::ModeDec)
    else $error("halt flag set in encode mode");

  // Encode jobs carry four results, decode jobs one to three.
  a_job_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_job.enc && push_job.cnt == 3'd4) ||
             (!push_job.enc && push_job.cnt >= 3'd1 && push_job.cnt <= 3'd3))
    else $error("job result count out of range");

  // The queue never takes a job while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("job pushed into full queue");

endmodule
